FILE: rtl/hidrep_pkg.sv
// Shared types and constants for the HID boot keyboard report builder.
// No dependencies; used by the interfaces, the core and the checker.
package hidrep_pkg;

  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned KEY_W        = 8;
  localparam int unsigned REPORT_SLOTS = 6;

  // Modifier usages occupy 0xE0..0xE7: top five bits fixed, low three pick the bit.
  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PRESS     = 2'd0,
    FUNC_RELEASE   = 2'd1,
    FUNC_CLEAR_ALL = 2'd2,
    FUNC_TAP       = 2'd3
  } func_e;

  function automatic logic [KEY_W-1:0] modifier_bit(input logic [KEY_W-1:0] code);
    logic [KEY_W-1:0] bits;
    bits = '0;
    if (code[KEY_W-1:3] == MOD_PREFIX) begin
      bits = KEY_W'(1) << code[2:0];
    end
    return bits;
  endfunction

endpackage

FILE: rtl/hidrep_if.sv
// Valid/ready channels for key events and keyboard reports.
// Depends on hidrep_pkg for field widths.
interface hidrep_in_if;
  logic                           valid;
  logic                           ready;
  logic [hidrep_pkg::FUNC_W-1:0]  func;
  logic [hidrep_pkg::KEY_W-1:0]   key_code;
  logic [hidrep_pkg::KEY_W-1:0]   modifier_mask;

  modport source (output valid, func, key_code, modifier_mask, input ready);
  modport sink   (input valid, func, key_code, modifier_mask, output ready);
endinterface

interface hidrep_out_if;
  logic                          valid;
  logic                          ready;
  logic [hidrep_pkg::KEY_W-1:0]  report_modifiers;
  logic [hidrep_pkg::KEY_W-1:0]  slot0;
  logic [hidrep_pkg::KEY_W-1:0]  slot1;
  logic [hidrep_pkg::KEY_W-1:0]  slot2;
  logic [hidrep_pkg::KEY_W-1:0]  slot3;
  logic [hidrep_pkg::KEY_W-1:0]  slot4;
  logic [hidrep_pkg::KEY_W-1:0]  slot5;
  logic                          last_report;

  modport source (output valid, report_modifiers, slot0, slot1, slot2, slot3, slot4, slot5,
                  last_report, input ready);
  modport sink   (input valid, report_modifiers, slot0, slot1, slot2, slot3, slot4, slot5,
                  last_report, output ready);
endinterface

FILE: rtl/hid_keyboard_report_builder_core.sv
// HID boot keyboard report builder core: modifier byte plus key slots, one
// slot compared per cycle. Depends on hidrep_pkg and hidrep_if.
// Sequence: accept, scan of every slot, finish (place a pressed key), load into the output
// register; a tap loads a second report, with modifiers and the tapped key cleared.
// Modifier-only press/release skips the scan and goes straight to the load; zero-code ones are dropped.
// The load waits for a free output register; a new event is accepted only when idle again.
// Reset (rst_ni low, async) clears modifiers, all slots and the output register.
module hid_keyboard_report_builder_core #(
  parameter int unsigned SLOT_COUNT = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  hidrep_in_if.sink           in_i,
  hidrep_out_if.source        out_o
);

  localparam int unsigned KW    = hidrep_pkg::KEY_W;
  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN,
    ST_EMIT
  } state_e;

  state_e                 state_q, state_d;
  hidrep_pkg::func_e      func_q, func_d;
  logic [KW-1:0]          code_q, code_d;
  logic [KW-1:0]          mods_q, mods_d;
  logic [KW-1:0]          slot_q [SLOT_COUNT];
  logic [KW-1:0]          slot_d [SLOT_COUNT];
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [IDX_W-1:0]       empty_q, empty_d;
  logic                   found_q, found_d;
  logic                   held_q, held_d;
  logic                   any_q, any_d;
  logic                   second_q, second_d;

  logic                   out_valid_q, out_valid_d;
  logic [KW-1:0]          out_mods_q, out_mods_d;
  logic [KW-1:0]          out_slot_q [hidrep_pkg::REPORT_SLOTS];
  logic [KW-1:0]          out_slot_d [hidrep_pkg::REPORT_SLOTS];
  logic                   out_last_q, out_last_d;

  logic [KW-1:0]          rpt_slot [hidrep_pkg::REPORT_SLOTS];
  logic [KW-1:0]          in_mbit;
  logic [KW-1:0]          cur_slot;
  logic                   cur_eq;
  logic                   cur_zero;

  // Report view of the slot file; slots past the array read as empty.
  for (genvar g = 0; g < hidrep_pkg::REPORT_SLOTS; g++) begin : g_rpt
    if (g < SLOT_COUNT) begin : g_live
      assign rpt_slot[g] = slot_q[g];
    end else begin : g_empty
      assign rpt_slot[g] = '0;
    end
  end

  assign in_mbit  = hidrep_pkg::modifier_bit(in_i.key_code);
  // Shared compare unit: one slot per cycle against the latched code.
  assign cur_slot = slot_q[idx_q];
  assign cur_eq   = (cur_slot == code_q);
  assign cur_zero = (cur_slot == '0);

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    code_d      = code_q;
    mods_d      = mods_q;
    slot_d      = slot_q;
    idx_d       = idx_q;
    empty_d     = empty_q;
    found_d     = found_q;
    held_d      = held_q;
    any_d       = any_q;
    second_d    = second_q;
    out_valid_d = out_valid_q;
    out_mods_d  = out_mods_q;
    out_slot_d  = out_slot_q;
    out_last_d  = out_last_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          func_d   = hidrep_pkg::func_e'(in_i.func);
          code_d   = in_i.key_code;
          idx_d    = '0;
          empty_d  = '0;
          found_d  = 1'b0;
          held_d   = 1'b0;
          any_d    = (mods_q != '0);
          second_d = 1'b0;
          case (hidrep_pkg::func_e'(in_i.func))
            hidrep_pkg::FUNC_PRESS, hidrep_pkg::FUNC_RELEASE: begin
              if (in_i.key_code == '0) begin
                state_d = ST_IDLE;
              end else if (in_mbit != '0) begin
                mods_d  = (in_i.func == hidrep_pkg::FUNC_PRESS) ? (mods_q | in_mbit)
                                                                : (mods_q & ~in_mbit);
                state_d = ST_EMIT;
              end else begin
                state_d = ST_SCAN;
              end
            end
            hidrep_pkg::FUNC_CLEAR_ALL: begin
              mods_d  = '0;
              state_d = ST_SCAN;
            end
            default: begin
              mods_d  = in_i.modifier_mask;
              state_d = ST_SCAN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        case (func_q)
          hidrep_pkg::FUNC_PRESS: begin
            if (cur_eq) begin
              held_d = 1'b1;
            end
            if (cur_zero && !found_q) begin
              found_d = 1'b1;
              empty_d = idx_q;
            end
          end
          hidrep_pkg::FUNC_RELEASE: begin
            if (cur_eq) begin
              slot_d[idx_q] = '0;
            end
          end
          hidrep_pkg::FUNC_CLEAR_ALL: begin
            if (!cur_zero) begin
              any_d = 1'b1;
            end
            slot_d[idx_q] = '0;
          end
          default: begin
            slot_d[idx_q] = (idx_q == '0) ? code_q : '0;
          end
        endcase
        if (idx_q == LAST_IDX) begin
          state_d = ST_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_FIN: begin
        state_d = ST_EMIT;
        if (func_q == hidrep_pkg::FUNC_PRESS) begin
          if (found_q && !held_q) begin
            slot_d[empty_q] = code_q;
          end
        end else if (func_q == hidrep_pkg::FUNC_CLEAR_ALL && !any_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_mods_d  = mods_q;
          out_slot_d  = rpt_slot;
          out_last_d  = (func_q != hidrep_pkg::FUNC_TAP) || second_q;
          if (func_q == hidrep_pkg::FUNC_TAP && !second_q) begin
            // Tap release half: drop modifiers and the tapped key, report again.
            mods_d    = '0;
            slot_d[0] = '0;
            second_d  = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      func_q      <= hidrep_pkg::FUNC_PRESS;
      code_q      <= '0;
      mods_q      <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_q[i] <= '0;
      end
      idx_q       <= '0;
      empty_q     <= '0;
      found_q     <= 1'b0;
      held_q      <= 1'b0;
      any_q       <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_mods_q  <= '0;
      for (int i = 0; i < hidrep_pkg::REPORT_SLOTS; i++) begin
        out_slot_q[i] <= '0;
      end
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      code_q      <= code_d;
      mods_q      <= mods_d;
      slot_q      <= slot_d;
      idx_q       <= idx_d;
      empty_q     <= empty_d;
      found_q     <= found_d;
      held_q      <= held_d;
      any_q       <= any_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
      out_mods_q  <= out_mods_d;
      out_slot_q  <= out_slot_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.report_modifiers = out_mods_q;
  assign out_o.slot0            = out_slot_q[0];
  assign out_o.slot1            = out_slot_q[1];
  assign out_o.slot2            = out_slot_q[2];
  assign out_o.slot3            = out_slot_q[3];
  assign out_o.slot4            = out_slot_q[4];
  assign out_o.slot5            = out_slot_q[5];
  assign out_o.last_report      = out_last_q;

endmodule

FILE: rtl/hidrep_checker.sv
// Port-level checks for the report builder core, attached by bind.
// Depends on hidrep_pkg and hidrep_if through the bound core's ports.
module hidrep_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [hidrep_pkg::FUNC_W-1:0] in_func_i,
  input logic [hidrep_pkg::KEY_W-1:0]  in_key_code_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_last_i
);

  logic in_dropped;

  // Zero-code press or release leaves the block idle.
  assign in_dropped = ((in_func_i == hidrep_pkg::FUNC_PRESS) ||
                       (in_func_i == hidrep_pkg::FUNC_RELEASE)) && (in_key_code_i == '0);

  // A pending report holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_last_i))
    else $error("report dropped or changed while stalled");

  // Accepting an item that is not dropped takes the block out of idle, so ready falls.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_dropped |=> !in_ready_i)
    else $error("new item accepted right after previous one");

  // While the first half of a tap waits, the second is still owed.
  a_tap_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("ready while a tap report is still owed");

  // Taking a non-final report brings the final one in the next cycle.
  a_tap_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_last_i)
    else $error("final tap report missing");

endmodule

bind hid_keyboard_report_builder_core hidrep_checker u_hidrep_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_func_i     (in_i.func),
  .in_key_code_i (in_i.key_code),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_last_i    (out_o.last_report)
);

FILE: bench/hid_keyboard_report_builder_core_test.sv
// Self-checking bench for hid_keyboard_report_builder_core: key events in, boot reports out.
// Depends on hidrep_pkg, hidrep_in_if / hidrep_out_if and the core RTL.
module hid_keyboard_report_builder_core_test;

  localparam int unsigned KW          = hidrep_pkg::KEY_W;
  localparam int unsigned RS          = hidrep_pkg::REPORT_SLOTS;
  localparam int unsigned NUM_SLOTS   = 6;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_ITEMS = 1600;

  typedef struct packed {
    logic [KW-1:0]         modifiers;
    logic [RS-1:0][KW-1:0] slots;
    logic                  last;
  } hid_report_t;

  // Tracks modifier byte and key slots, queues the reports each event should produce.
  class report_tracker #(int unsigned SLOTS = NUM_SLOTS);
    logic [KW-1:0] held_mods;
    logic [KW-1:0] held_keys [SLOTS];
    hid_report_t   upcoming_reports [$];
    int unsigned   mismatches;

    function new();
      clear_keys();
      mismatches = 0;
    endfunction

    function void clear_keys();
      held_mods = '0;
      foreach (held_keys[i]) held_keys[i] = '0;
    endfunction

    function logic [KW-1:0] mod_bit_for(logic [KW-1:0] code);
      logic [KW-1:0] bits;
      bits = '0;
      if (code[KW-1:3] == hidrep_pkg::MOD_PREFIX) bits[code[2:0]] = 1'b1;
      return bits;
    endfunction

    function void queue_report(logic last);
      hid_report_t rep;
      rep.modifiers = held_mods;
      for (int i = 0; i < RS; i++)
        rep.slots[i] = (i < SLOTS) ? held_keys[i] : '0;
      rep.last = last;
      upcoming_reports.push_back(rep);
    endfunction

    function void note_key_event(hidrep_pkg::func_e op, logic [KW-1:0] code,
                                 logic [KW-1:0] mask);
      logic [KW-1:0] mbit;
      logic [KW-1:0] any_set;
      bit            already;
      bit            placed;
      mbit = mod_bit_for(code);
      case (op)
        hidrep_pkg::FUNC_PRESS, hidrep_pkg::FUNC_RELEASE: begin
          if (code == '0) return;
          if (op == hidrep_pkg::FUNC_PRESS) begin
            if (mbit != '0) begin
              held_mods |= mbit;
            end else begin
              already = 1'b0;
              foreach (held_keys[i]) if (held_keys[i] == code) already = 1'b1;
              placed = already;
              foreach (held_keys[i]) begin
                if (!placed && held_keys[i] == '0) begin
                  held_keys[i] = code;
                  placed = 1'b1;
                end
              end
            end
          end else begin
            if (mbit != '0) held_mods &= ~mbit;
            else foreach (held_keys[i]) if (held_keys[i] == code) held_keys[i] = '0;
          end
          queue_report(1'b1);
        end
        hidrep_pkg::FUNC_CLEAR_ALL: begin
          any_set = held_mods;
          foreach (held_keys[i]) any_set |= held_keys[i];
          clear_keys();
          if (any_set != '0) queue_report(1'b1);
        end
        default: begin
          clear_keys();
          held_mods    = mask;
          held_keys[0] = code;
          queue_report(1'b0);
          held_mods    = '0;
          held_keys[0] = '0;
          queue_report(1'b1);
        end
      endcase
    endfunction

    function void check_report(hid_report_t seen);
      hid_report_t want;
      if (upcoming_reports.size() == 0) begin
        $error("unexpected report: modifiers %02h slots %h last %0b",
               seen.modifiers, seen.slots, seen.last);
        mismatches++;
        return;
      end
      want = upcoming_reports.pop_front();
      if (seen.modifiers !== want.modifiers) begin
        $error("report_modifiers: expected %02h, actual %02h", want.modifiers, seen.modifiers);
        mismatches++;
      end
      for (int i = 0; i < RS; i++) begin
        if (seen.slots[i] !== want.slots[i]) begin
          $error("slot%0d: expected %02h, actual %02h", i, want.slots[i], seen.slots[i]);
          mismatches++;
        end
      end
      if (seen.last !== want.last) begin
        $error("last_report: expected %0b, actual %0b", want.last, seen.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned cycle_count;
  report_tracker tracker;

  hidrep_in_if  event_bus ();
  hidrep_out_if report_bus ();

  hid_keyboard_report_builder_core #(
    .SLOT_COUNT(NUM_SLOTS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (event_bus),
    .out_o (report_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL hid_keyboard_report_builder_core");
    $finish;
  end

  // Both handshakes are sampled at the edge, before this step's drives land.
  always @(posedge clk_i) begin
    hid_report_t seen;
    if (rst_ni && event_bus.valid && event_bus.ready)
      tracker.note_key_event(hidrep_pkg::func_e'(event_bus.func), event_bus.key_code,
                             event_bus.modifier_mask);
    if (rst_ni && report_bus.valid && report_bus.ready) begin
      seen.modifiers = report_bus.report_modifiers;
      seen.slots[0]  = report_bus.slot0;
      seen.slots[1]  = report_bus.slot1;
      seen.slots[2]  = report_bus.slot2;
      seen.slots[3]  = report_bus.slot3;
      seen.slots[4]  = report_bus.slot4;
      seen.slots[5]  = report_bus.slot5;
      seen.last      = report_bus.last_report;
      tracker.check_report(seen);
    end
  end

  // Receiver: picks a new stall style whenever the current one runs out.
  initial begin
    int  stall_mode;
    int  mode_left;
    int  hold_left;
    bit  hold_val;
    bit  ready_next;
    stall_mode = 0;
    mode_left  = 0;
    hold_left  = 0;
    hold_val   = 1'b0;
    report_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 256);
      end
      mode_left--;
      case (stall_mode)
        0: ready_next = 1'b1;
        1: ready_next = 1'($urandom_range(0, 1));
        2: ready_next = ($urandom_range(0, 3) == 0);
        default: begin
          if (hold_left == 0) begin
            hold_left = $urandom_range(1, 20);
            hold_val  = ~hold_val;
          end
          hold_left--;
          ready_next = hold_val;
        end
      endcase
      report_bus.ready <= ready_next;
    end
  end

  task automatic send_key_event(hidrep_pkg::func_e op, logic [KW-1:0] code,
                                logic [KW-1:0] mask);
    event_bus.valid         <= 1'b1;
    event_bus.func          <= op;
    event_bus.key_code      <= code;
    event_bus.modifier_mask <= mask;
    @(posedge clk_i);
    while (!event_bus.ready) @(posedge clk_i);
  endtask

  task automatic pause_sender(int cycles);
    event_bus.valid         <= 1'b0;
    event_bus.func          <= hidrep_pkg::func_e'(2'($urandom_range(0, 3)));
    event_bus.key_code      <= KW'($urandom_range(0, 255));
    event_bus.modifier_mask <= KW'($urandom_range(0, 255));
    repeat (cycles) @(posedge clk_i);
  endtask

  // Steps past the current edge first so the monitor has noted the last accepted item.
  task automatic wait_reports_drained();
    @(posedge clk_i);
    while (tracker.upcoming_reports.size() != 0) @(posedge clk_i);
  endtask

  // Mostly a small pool so slots fill up and releases hit held keys.
  function automatic logic [KW-1:0] pick_key_code();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return KW'(8'h04 + $urandom_range(0, 7));
    if (roll < 75) return KW'(8'hE0 + $urandom_range(0, 7));
    if (roll < 82) return '0;
    return KW'($urandom_range(0, 255));
  endfunction

  initial begin
    int                burst_left;
    int                roll;
    int unsigned       counted;
    hidrep_pkg::func_e op;
    logic [KW-1:0]     code;
    tracker = new();
    rst_ni  = 1'b0;
    event_bus.valid         <= 1'b0;
    event_bus.func          <= hidrep_pkg::FUNC_PRESS;
    event_bus.key_code      <= '0;
    event_bus.modifier_mask <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    pause_sender(3);

    // Directed: zero codes, modifier edges, full slots, duplicates, taps.
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'h00, 8'hFF);
    send_key_event(hidrep_pkg::FUNC_RELEASE,   8'h00, 8'hFF);
    send_key_event(hidrep_pkg::FUNC_CLEAR_ALL, 8'h00, 8'h00);
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'hE0, 8'h00);
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'hE7, 8'h00);
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'hDF, 8'h00);
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'hE8, 8'h00);
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'hFF, 8'h00);
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'h01, 8'h00);
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'h04, 8'h00);
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'h05, 8'h00);
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'h06, 8'h00);
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'hFF, 8'h00);
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'hE0, 8'h00);
    send_key_event(hidrep_pkg::FUNC_RELEASE,   8'hE0, 8'h00);
    send_key_event(hidrep_pkg::FUNC_RELEASE,   8'h05, 8'h00);
    send_key_event(hidrep_pkg::FUNC_PRESS,     8'h06, 8'h00);
    send_key_event(hidrep_pkg::FUNC_RELEASE,   8'h10, 8'h00);
    send_key_event(hidrep_pkg::FUNC_RELEASE,   8'hE3, 8'h00);
    send_key_event(hidrep_pkg::FUNC_CLEAR_ALL, 8'h00, 8'h00);
    send_key_event(hidrep_pkg::FUNC_TAP,       8'hFF, 8'hFF);
    send_key_event(hidrep_pkg::FUNC_TAP,       8'h00, 8'h00);
    send_key_event(hidrep_pkg::FUNC_TAP,       8'hE3, 8'hA5);
    send_key_event(hidrep_pkg::FUNC_CLEAR_ALL, 8'hFF, 8'hFF);
    send_key_event(hidrep_pkg::FUNC_TAP,       8'h7F, 8'h5A);
    pause_sender(1);
    wait_reports_drained();

    burst_left = 0;
    counted    = 0;
    while (counted < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        pause_sender($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 16);
      end
      if (counted == RANDOM_ITEMS / 2) begin
        pause_sender(1);
        wait_reports_drained();
      end
      roll = $urandom_range(0, 99);
      if (roll < 42)      op = hidrep_pkg::FUNC_PRESS;
      else if (roll < 80) op = hidrep_pkg::FUNC_RELEASE;
      else if (roll < 90) op = hidrep_pkg::FUNC_CLEAR_ALL;
      else                op = hidrep_pkg::FUNC_TAP;
      code = pick_key_code();
      send_key_event(op, code, KW'($urandom_range(0, 255)));
      burst_left--;
      // zero-code press and release are dropped by the block
      if (!((op == hidrep_pkg::FUNC_PRESS || op == hidrep_pkg::FUNC_RELEASE) && code == '0))
        counted++;
    end
    pause_sender(1);
    wait_reports_drained();
    repeat (24) @(posedge clk_i);

    if (tracker.upcoming_reports.size() != 0) begin
      $error("%0d expected reports never arrived", tracker.upcoming_reports.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0)
      $display("PASS hid_keyboard_report_builder_core");
    else
      $display("FAIL hid_keyboard_report_builder_core");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/hidrep_pkg.sv
rtl/hidrep_if.sv
rtl/hid_keyboard_report_builder_core.sv
rtl/hidrep_checker.sv
bench/hid_keyboard_report_builder_core_test.sv
